>>> rtl/yvc_pkg.sv
// ----------------------------------------------------------------------------
// yvc_pkg
// Shared constants, payload types and arithmetic helpers for the YVU 4:2:0
// to BGRA converter.
// ----------------------------------------------------------------------------
package yvc_pkg;

   localparam int SAMPLE_WIDTH = 8;
   localparam int PIXEL_WIDTH  = 32;
   localparam int SUM_WIDTH    = 16;
   localparam int FRAC_BITS    = 6;

   localparam logic signed [SUM_WIDTH-1:0] COEF_B_U      = 16'sd111;
   localparam logic signed [SUM_WIDTH-1:0] COEF_G_V      = -16'sd45;
   localparam logic signed [SUM_WIDTH-1:0] COEF_G_U      = -16'sd22;
   localparam logic signed [SUM_WIDTH-1:0] COEF_R_V      = 16'sd88;
   localparam logic signed [SUM_WIDTH-1:0] CHROMA_OFFSET = 16'sd128;
   localparam logic signed [SUM_WIDTH-1:0] CLAMP_HIGH    = 16'sd16320;

   localparam logic [SAMPLE_WIDTH-1:0] ALPHA_RESET = 8'hFF;

   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] luma_upper_left;
      logic [SAMPLE_WIDTH-1:0] luma_upper_right;
      logic [SAMPLE_WIDTH-1:0] luma_lower_left;
      logic [SAMPLE_WIDTH-1:0] luma_lower_right;
      logic [SAMPLE_WIDTH-1:0] chroma_v;
      logic [SAMPLE_WIDTH-1:0] chroma_u;
   } req_payload_type;

   typedef struct packed {
      logic [PIXEL_WIDTH-1:0] pixel_upper_left;
      logic [PIXEL_WIDTH-1:0] pixel_upper_right;
      logic [PIXEL_WIDTH-1:0] pixel_lower_left;
      logic [PIXEL_WIDTH-1:0] pixel_lower_right;
   } rsp_payload_type;

   // Chroma contributions shared by all four pixels of a block.
   typedef struct packed {
      logic signed [SUM_WIDTH-1:0] add_b;
      logic signed [SUM_WIDTH-1:0] add_g;
      logic signed [SUM_WIDTH-1:0] add_r;
   } chroma_terms_type;

   // Clamps a scaled sum to the legal range and drops the fraction bits.
   function automatic logic [SAMPLE_WIDTH-1:0] channel_byte(
      input logic signed [SUM_WIDTH-1:0] sum);
      logic [SAMPLE_WIDTH-1:0] result;
      priority if (sum < 0) begin
         result = '0;
      end else if (sum > CLAMP_HIGH) begin
         result = SAMPLE_WIDTH'(CLAMP_HIGH >>> FRAC_BITS);
      end else begin
         result = sum[FRAC_BITS +: SAMPLE_WIDTH];
      end
      return result;
   endfunction

endpackage

>>> rtl/yvc_req_if.sv
// ----------------------------------------------------------------------------
// yvc_req_if
// Request channel: one 2x2 block of luma samples and its shared chroma pair.
// ----------------------------------------------------------------------------
interface yvc_req_if
   import yvc_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [SAMPLE_WIDTH-1:0] luma_upper_left;
   logic [SAMPLE_WIDTH-1:0] luma_upper_right;
   logic [SAMPLE_WIDTH-1:0] luma_lower_left;
   logic [SAMPLE_WIDTH-1:0] luma_lower_right;
   logic [SAMPLE_WIDTH-1:0] chroma_v;
   logic [SAMPLE_WIDTH-1:0] chroma_u;

   modport source (
      output valid, luma_upper_left, luma_upper_right, luma_lower_left,
             luma_lower_right, chroma_v, chroma_u,
      input  ready
   );

   modport sink (
      input  valid, luma_upper_left, luma_upper_right, luma_lower_left,
             luma_lower_right, chroma_v, chroma_u,
      output ready
   );

   modport monitor (
      input valid, ready, luma_upper_left, luma_upper_right, luma_lower_left,
            luma_lower_right, chroma_v, chroma_u
   );
endinterface

>>> rtl/yvc_rsp_if.sv
// ----------------------------------------------------------------------------
// yvc_rsp_if
// Response channel: the four BGRA pixels of one converted 2x2 block.
// ----------------------------------------------------------------------------
interface yvc_rsp_if
   import yvc_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [PIXEL_WIDTH-1:0] pixel_upper_left;
   logic [PIXEL_WIDTH-1:0] pixel_upper_right;
   logic [PIXEL_WIDTH-1:0] pixel_lower_left;
   logic [PIXEL_WIDTH-1:0] pixel_lower_right;

   modport source (
      output valid, pixel_upper_left, pixel_upper_right, pixel_lower_left,
             pixel_lower_right,
      input  ready
   );

   modport sink (
      input  valid, pixel_upper_left, pixel_upper_right, pixel_lower_left,
             pixel_lower_right,
      output ready
   );

   modport monitor (
      input valid, ready, pixel_upper_left, pixel_upper_right,
            pixel_lower_left, pixel_lower_right
   );
endinterface

>>> rtl/yvc_chroma.sv
// ----------------------------------------------------------------------------
// yvc_chroma
// Removes the chroma offset and forms the three chroma terms of the block.
// ----------------------------------------------------------------------------
module yvc_chroma
   import yvc_pkg::*;
(
   input  logic [SAMPLE_WIDTH-1:0] chroma_v,
   input  logic [SAMPLE_WIDTH-1:0] chroma_u,
   output chroma_terms_type        terms
);

   logic signed [SUM_WIDTH-1:0] v_off;
   logic signed [SUM_WIDTH-1:0] u_off;

   assign v_off = signed'(SUM_WIDTH'(chroma_v)) - CHROMA_OFFSET;
   assign u_off = signed'(SUM_WIDTH'(chroma_u)) - CHROMA_OFFSET;

   // All products and sums stay within 16 signed bits for any input.
   assign terms.add_b = SUM_WIDTH'(COEF_B_U * u_off);
   assign terms.add_g = SUM_WIDTH'(COEF_G_V * v_off + COEF_G_U * u_off);
   assign terms.add_r = SUM_WIDTH'(COEF_R_V * v_off);

endmodule

>>> rtl/yvc_pixel.sv
// ----------------------------------------------------------------------------
// yvc_pixel
// Builds one BGRA word from a luma sample, the chroma terms and alpha.
// ----------------------------------------------------------------------------
module yvc_pixel
   import yvc_pkg::*;
(
   input  logic [SAMPLE_WIDTH-1:0] luma,
   input  chroma_terms_type        terms,
   input  logic [SAMPLE_WIDTH-1:0] alpha,
   output logic [PIXEL_WIDTH-1:0]  pixel
);

   logic signed [SUM_WIDTH-1:0] y_scaled;
   logic [SAMPLE_WIDTH-1:0]     blue;
   logic [SAMPLE_WIDTH-1:0]     green;
   logic [SAMPLE_WIDTH-1:0]     red;

   assign y_scaled = signed'(SUM_WIDTH'(luma) << FRAC_BITS);

   assign blue  = channel_byte(SUM_WIDTH'(y_scaled + terms.add_b));
   assign green = channel_byte(SUM_WIDTH'(y_scaled + terms.add_g));
   assign red   = channel_byte(SUM_WIDTH'(y_scaled + terms.add_r));

   assign pixel = {alpha, red, green, blue};

endmodule

>>> rtl/yvu420_to_bgra_converter.sv
// ----------------------------------------------------------------------------
// yvu420_to_bgra_converter
// Converts full-range YVU 4:2:0, one 2x2 block per request, to BGRA pixels.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                               Handshake
//   req       in         4 luma samples, V and U               valid/ready
//   rsp       out        4 BGRA words                          valid/ready
//   csr       in         alpha byte                            write enable
//
// A request is registered, converted combinationally and held in the output
// register; one request is accepted per cycle while the response is not
// stalled. The throughput is set by the single conversion stage between the
// two registers. Reset clears both valid flags and sets alpha to 0xFF. A
// stalled response holds the output register; a new request is still
// accepted while the input register is empty or moves on.
// ----------------------------------------------------------------------------
module yvu420_to_bgra_converter
   import yvc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   yvc_req_if.sink                 req_channel,
   yvc_rsp_if.source               rsp_channel,
   input  logic                    csr_write_enable,
   input  logic [SAMPLE_WIDTH-1:0] csr_write_data
);

   logic                    in_valid_ff, in_valid_in;
   req_payload_type         in_data_ff, in_data_in;
   logic                    out_valid_ff, out_valid_in;
   rsp_payload_type         out_data_ff, out_data_in;
   logic [SAMPLE_WIDTH-1:0] alpha_ff, alpha_in;

   logic                    out_advance;
   logic                    in_advance;
   chroma_terms_type        terms;
   rsp_payload_type         converted;

   assign out_advance = !out_valid_ff || rsp_channel.ready;
   assign in_advance  = !in_valid_ff || out_advance;

   assign req_channel.ready = in_advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      alpha_in     = csr_write_enable ? csr_write_data : alpha_ff;
      if (in_advance) begin
         in_valid_in                 = req_channel.valid;
         in_data_in.luma_upper_left  = req_channel.luma_upper_left;
         in_data_in.luma_upper_right = req_channel.luma_upper_right;
         in_data_in.luma_lower_left  = req_channel.luma_lower_left;
         in_data_in.luma_lower_right = req_channel.luma_lower_right;
         in_data_in.chroma_v         = req_channel.chroma_v;
         in_data_in.chroma_u         = req_channel.chroma_u;
      end
      if (out_advance) begin
         out_valid_in = in_valid_ff;
         out_data_in  = converted;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         alpha_ff     <= ALPHA_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         alpha_ff     <= alpha_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   yvc_chroma u_chroma (
      .chroma_v (in_data_ff.chroma_v),
      .chroma_u (in_data_ff.chroma_u),
      .terms    (terms)
   );

   yvc_pixel u_pixel_upper_left (
      .luma  (in_data_ff.luma_upper_left),
      .terms (terms),
      .alpha (alpha_ff),
      .pixel (converted.pixel_upper_left)
   );

   yvc_pixel u_pixel_upper_right (
      .luma  (in_data_ff.luma_upper_right),
      .terms (terms),
      .alpha (alpha_ff),
      .pixel (converted.pixel_upper_right)
   );

   yvc_pixel u_pixel_lower_left (
      .luma  (in_data_ff.luma_lower_left),
      .terms (terms),
      .alpha (alpha_ff),
      .pixel (converted.pixel_lower_left)
   );

   yvc_pixel u_pixel_lower_right (
      .luma  (in_data_ff.luma_lower_right),
      .terms (terms),
      .alpha (alpha_ff),
      .pixel (converted.pixel_lower_right)
   );

   assign rsp_channel.valid             = out_valid_ff;
   assign rsp_channel.pixel_upper_left  = out_data_ff.pixel_upper_left;
   assign rsp_channel.pixel_upper_right = out_data_ff.pixel_upper_right;
   assign rsp_channel.pixel_lower_left  = out_data_ff.pixel_lower_left;
   assign rsp_channel.pixel_lower_right = out_data_ff.pixel_lower_right;

endmodule

>>> rtl/yvc_checker.sv
// ----------------------------------------------------------------------------
// yvc_checker
// Port-level checks on the converter: pipeline timing, flow and alpha.
// ----------------------------------------------------------------------------
module yvc_checker
   import yvc_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [PIXEL_WIDTH-1:0] pixel_upper_left,
   input logic [PIXEL_WIDTH-1:0] pixel_upper_right,
   input logic [PIXEL_WIDTH-1:0] pixel_lower_left,
   input logic [PIXEL_WIDTH-1:0] pixel_lower_right
);

   logic req_fire;

   assign req_fire = req_valid && req_ready;

   // Reset empties the pipeline.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A request accepted always leads to a valid response once it has passed the input register.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> ##1 rsp_valid)
      else $error("accepted request did not reach the output");

   // With nothing waiting at the output the block must take requests.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled while output is empty");

   // All four pixels carry the same alpha byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (pixel_upper_left[PIXEL_WIDTH-1 -: SAMPLE_WIDTH]
             == pixel_upper_right[PIXEL_WIDTH-1 -: SAMPLE_WIDTH])
         && (pixel_upper_left[PIXEL_WIDTH-1 -: SAMPLE_WIDTH]
             == pixel_lower_left[PIXEL_WIDTH-1 -: SAMPLE_WIDTH])
         && (pixel_upper_left[PIXEL_WIDTH-1 -: SAMPLE_WIDTH]
             == pixel_lower_right[PIXEL_WIDTH-1 -: SAMPLE_WIDTH]))
      else $error("alpha differs between pixels of one response");

   // A stalled response stays valid and holds its upper-left and lower-right pixels.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid
         && $stable(pixel_upper_left)
         && $stable(pixel_lower_right))
      else $error("stalled response changed");

endmodule

bind yvu420_to_bgra_converter yvc_checker u_yvc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_channel.valid),
   .req_ready         (req_channel.ready),
   .rsp_valid         (rsp_channel.valid),
   .rsp_ready         (rsp_channel.ready),
   .pixel_upper_left  (rsp_channel.pixel_upper_left),
   .pixel_upper_right (rsp_channel.pixel_upper_right),
   .pixel_lower_left  (rsp_channel.pixel_lower_left),
   .pixel_lower_right (rsp_channel.pixel_lower_right)
);

>>> sim/tb_yvu420_to_bgra_converter.sv
// ----------------------------------------------------------------------------
// tb_yvu420_to_bgra_converter
// Drives 2x2 YVU blocks into the converter and checks every BGRA response
// against a behavioral color-conversion predictor or typed-in words. A short
// corner table precedes random blocks under varying sender and receiver
// stalls, a long response hold-off and several alpha register settings.
// ----------------------------------------------------------------------------
module tb_yvu420_to_bgra_converter;
   import yvc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_HALF_NS   = 6;
   localparam int RESET_CYCLES    = 12;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int TAIL_CYCLES     = 10;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int MAX_REPORTS     = 100;
   localparam int SCALED_MAX      = 16320;
   localparam int NEUTRAL_CHROMA  = 128;
   localparam int DIRECTED_ROWS   = 18;

   typedef struct packed {
      logic            use_literal;
      req_payload_type blk;
      rsp_payload_type literal;
   } directed_row_type;

   // Rows with neutral chroma give gray pixels, so their words are typed in.
   localparam directed_row_type DIRECTED_TABLE [DIRECTED_ROWS] = '{
      '{1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h80},
            '{32'hFF000000, 32'hFF000000, 32'hFF000000, 32'hFF000000}},
      '{1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h80},
            '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF}},
      '{1'b1, '{8'h80, 8'h01, 8'hFE, 8'h55, 8'h80, 8'h80},
            '{32'hFF808080, 32'hFF010101, 32'hFFFEFEFE, 32'hFF555555}},
      '{1'b0, '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF}, '0},
      '{1'b0, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00}, '0},
      '{1'b0, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, '0},
      '{1'b0, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, '0},
      '{1'b0, '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF}, '0},
      '{1'b0, '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00}, '0},
      '{1'b0, '{8'h10, 8'h40, 8'hC0, 8'hF0, 8'h80, 8'hFF}, '0},
      '{1'b0, '{8'h10, 8'h40, 8'hC0, 8'hF0, 8'h80, 8'h00}, '0},
      '{1'b0, '{8'h10, 8'h40, 8'hC0, 8'hF0, 8'hFF, 8'h80}, '0},
      '{1'b0, '{8'h10, 8'h40, 8'hC0, 8'hF0, 8'h00, 8'h80}, '0},
      '{1'b0, '{8'hAA, 8'h55, 8'hF0, 8'h0F, 8'hAA, 8'h55}, '0},
      '{1'b0, '{8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h55, 8'hAA}, '0},
      '{1'b0, '{8'h7F, 8'h80, 8'h81, 8'h7E, 8'h81, 8'h7F}, '0},
      '{1'b0, '{8'h01, 8'h02, 8'h04, 8'h08, 8'h01, 8'hFE}, '0},
      '{1'b0, '{8'h20, 8'h08, 8'h10, 8'h01, 8'h7F, 8'h81}, '0}
   };

   logic                    clock;
   logic                    reset;
   logic                    csr_write_enable;
   logic [SAMPLE_WIDTH-1:0] csr_write_data;

   yvc_req_if req_bus ();
   yvc_rsp_if rsp_bus ();

   yvu420_to_bgra_converter dut (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (req_bus),
      .rsp_channel      (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   rsp_payload_type         pixel_expect_q [$];
   logic [SAMPLE_WIDTH-1:0] alpha_shadow;
   int                      send_idle_pct;
   int                      rcv_idle_pct;
   bit                      hold_off_pending;
   int                      hold_left;
   int                      error_count;
   int                      request_count;
   int                      response_count;
   int                      alpha_settings;
   int                      cycle_count;

   always #(CLOCK_HALF_NS) clock = ~clock;

   function automatic logic [7:0] clamp_to_byte(int sum);
      if (sum < 0) begin
         return 8'd0;
      end
      if (sum > SCALED_MAX) begin
         return 8'd255;
      end
      return 8'(sum / 64);
   endfunction

   // Expected BGRA words for one 2x2 block at the given alpha.
   function automatic rsp_payload_type convert_block(req_payload_type blk,
                                                     logic [7:0] alpha);
      logic [3:0][7:0]  lumas;
      logic [3:0][31:0] words;
      int               v_off;
      int               u_off;
      int               add_b;
      int               add_g;
      int               add_r;
      int               y64;
      lumas = {blk.luma_upper_left, blk.luma_upper_right,
               blk.luma_lower_left, blk.luma_lower_right};
      v_off = int'(blk.chroma_v) - NEUTRAL_CHROMA;
      u_off = int'(blk.chroma_u) - NEUTRAL_CHROMA;
      add_b = 111 * u_off;
      add_g = -45 * v_off - 22 * u_off;
      add_r = 88 * v_off;
      for (int k = 0; k < 4; k++) begin
         y64 = int'(lumas[k]) * 64;
         words[k] = {alpha, clamp_to_byte(y64 + add_r), clamp_to_byte(y64 + add_g),
                     clamp_to_byte(y64 + add_b)};
      end
      return rsp_payload_type'(words);
   endfunction

   // Mostly uniform samples, with a share of range corners to hit the clamps.
   function automatic logic [7:0] random_sample();
      if ($urandom_range(3) == 0) begin
         case ($urandom_range(5))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd127;
            3: return 8'd128;
            4: return 8'd254;
            default: return 8'd255;
         endcase
      end
      return 8'($urandom_range(255));
   endfunction

   task automatic report_failure(string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("%0t ns: mismatch: %s", $time, msg);
      end
   endtask

   // Offers one request and returns at the edge where it is taken. Valid is
   // left high so that back-to-back requests need no extra edge.
   task automatic send_block(req_payload_type blk, bit use_literal,
                             rsp_payload_type literal);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.luma_upper_left  <= blk.luma_upper_left;
      req_bus.luma_upper_right <= blk.luma_upper_right;
      req_bus.luma_lower_left  <= blk.luma_lower_left;
      req_bus.luma_lower_right <= blk.luma_lower_right;
      req_bus.chroma_v         <= blk.chroma_v;
      req_bus.chroma_u         <= blk.chroma_u;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      request_count++;
      pixel_expect_q.push_back(use_literal ? literal : convert_block(blk, alpha_shadow));
   endtask

   task automatic send_random_blocks(int count);
      req_payload_type blk;
      for (int n = 0; n < count; n++) begin
         blk.luma_upper_left  = random_sample();
         blk.luma_upper_right = random_sample();
         blk.luma_lower_left  = random_sample();
         blk.luma_lower_right = random_sample();
         blk.chroma_v         = random_sample();
         blk.chroma_u         = random_sample();
         send_block(blk, 1'b0, '0);
      end
   endtask

   task automatic wait_until_drained();
      req_bus.valid <= 1'b0;
      while (pixel_expect_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_alpha(logic [7:0] value);
      wait_until_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      alpha_shadow = value;
      alpha_settings++;
   endtask

   // Response ready: random stalls, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_off_pending) begin
         hold_left = HOLD_OFF_CYCLES;
         hold_off_pending = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_payload_type  want;
      logic [3:0][31:0] got_words;
      logic [3:0][31:0] want_words;
      string            pixel_names [4];
      pixel_names = '{"lower right", "lower left", "upper right", "upper left"};
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         response_count++;
         got_words = {rsp_bus.pixel_upper_left, rsp_bus.pixel_upper_right,
                      rsp_bus.pixel_lower_left, rsp_bus.pixel_lower_right};
         if (pixel_expect_q.size() == 0) begin
            report_failure($sformatf("response %0d arrived with no request waiting",
                                     response_count));
         end else begin
            want = pixel_expect_q.pop_front();
            want_words = want;
            for (int k = 0; k < 4; k++) begin
               if (got_words[k] !== want_words[k]) begin
                  report_failure($sformatf("response %0d pixel %s: got %08h, expected %08h",
                                           response_count, pixel_names[k],
                                           got_words[k], want_words[k]));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles without draining.", cycle_count);
         $display("tb_yvu420_to_bgra_converter: FAIL");
         $finish;
      end
   end

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_bus.valid            = 1'b0;
      req_bus.luma_upper_left  = '0;
      req_bus.luma_upper_right = '0;
      req_bus.luma_lower_left  = '0;
      req_bus.luma_lower_right = '0;
      req_bus.chroma_v         = '0;
      req_bus.chroma_u         = '0;
      rsp_bus.ready    = 1'b0;
      alpha_shadow     = ALPHA_RESET;
      send_idle_pct    = 0;
      rcv_idle_pct     = 0;
      hold_off_pending = 1'b0;
      hold_left        = 0;
      error_count      = 0;
      request_count    = 0;
      response_count   = 0;
      alpha_settings   = 1;
      cycle_count      = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Corner blocks at the reset alpha.
      for (int k = 0; k < DIRECTED_ROWS; k++) begin
         send_block(DIRECTED_TABLE[k].blk, DIRECTED_TABLE[k].use_literal,
                    DIRECTED_TABLE[k].literal);
      end

      write_alpha(8'h00);
      send_idle_pct = 14;
      rcv_idle_pct  = 78;
      send_random_blocks(600);

      write_alpha(8'($urandom_range(1, 254)));
      send_idle_pct = 78;
      rcv_idle_pct  = 14;
      send_random_blocks(600);

      write_alpha(8'hFF);
      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      send_random_blocks(250);

      // The receiver holds off while requests keep coming, so the input stalls.
      wait_until_drained();
      hold_off_pending = 1'b1;
      send_random_blocks(40);
      wait_until_drained();

      write_alpha(8'h80);
      send_random_blocks(310);

      wait_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pixel_expect_q.size() != 0) begin
         report_failure($sformatf("%0d expected responses never arrived",
                                  pixel_expect_q.size()));
      end

      $display("Converted %0d blocks into %0d checked responses across %0d alpha values,",
               request_count, response_count, alpha_settings);
      $display("with clamp corners, sender and receiver stalls and a long output hold-off.");
      if (error_count == 0) begin
         $display("tb_yvu420_to_bgra_converter: PASS");
      end else begin
         $display("tb_yvu420_to_bgra_converter: FAIL");
      end
      $finish;
   end

endmodule
